@@ src/aae_pkg.sv @@
`default_nettype none
package aae_pkg;

	localparam int TABLE_SIZE  = 258;
	localparam int TOTAL_INDEX = 257;
	localparam int SYM_W       = 9;
	localparam int CNT_W       = 16;
	localparam int PEND_W      = 32;
	localparam int GROUP       = 16;
	localparam int NGROUPS     = (TABLE_SIZE + GROUP - 1) / GROUP;

	localparam logic [SYM_W-1:0] EOS_SYMBOL = 9'd256;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             inc;
		logic             clr;
	} tbl_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] hi_cnt;
		logic [CNT_W-1:0] lo_cnt;
	} cnt_pair_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK1,
		ST_LOOK2,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_RENORM,
		ST_FLUSH_DRAIN
	} state_t;

	typedef enum logic {
		PH_FLUSH,
		PH_DRAIN
	} phase_t;

endpackage
`default_nettype wire

@@ src/aae_if.sv @@
`default_nettype none
interface aae_sym_if;
	logic                       valid;
	logic                       ready;
	logic [aae_pkg::SYM_W-1:0] symbol;
	modport source (output valid, output symbol, input ready);
	modport sink (input valid, input symbol, output ready);
endinterface

interface aae_res_if;
	logic                        valid;
	logic                        ready;
	logic                        lead_bit;
	logic [aae_pkg::PEND_W-1:0] follow_count;
	logic                        last;
	logic                        stream_end;
	modport source (output valid, output lead_bit, output follow_count, output last,
		output stream_end, input ready);
	modport sink (input valid, input lead_bit, input follow_count, input last,
		input stream_end, output ready);
endinterface
`default_nettype wire

@@ src/aae_cell.sv @@
`default_nettype none
module aae_cell #(
	parameter int INDEX = 0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire aae_pkg::tbl_ctl_t         ctl,
	input  wire logic [aae_pkg::CNT_W-1:0] next_cnt,
	output logic      [aae_pkg::CNT_W-1:0] cnt,
	output aae_pkg::cnt_pair_t             pair
);

	localparam logic [aae_pkg::SYM_W-1:0] IDX = aae_pkg::SYM_W'(INDEX);
	localparam logic [aae_pkg::CNT_W-1:0] INIT = aae_pkg::CNT_W'(INDEX);

	logic [aae_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= INIT;
		end else if (ctl.clr) begin
			cnt_q <= INIT;
		end else if (ctl.inc && (IDX > ctl.sym)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign cnt = cnt_q;

	always_comb begin
		if (ctl.sym == IDX) begin
			pair.lo_cnt = cnt_q;
			pair.hi_cnt = next_cnt;
		end else begin
			pair = '0;
		end
	end

endmodule
`default_nettype wire

@@ src/aae_table.sv @@
`default_nettype none
module aae_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire aae_pkg::tbl_ctl_t         ctl,
	output aae_pkg::cnt_pair_t             pair,
	output logic      [aae_pkg::CNT_W-1:0] total
);

	logic [aae_pkg::CNT_W-1:0] cnt [aae_pkg::TABLE_SIZE];
	aae_pkg::cnt_pair_t        cpair [aae_pkg::TABLE_SIZE];
	aae_pkg::cnt_pair_t        grp_s1 [aae_pkg::NGROUPS];
	aae_pkg::cnt_pair_t        grp_or [aae_pkg::NGROUPS];
	aae_pkg::cnt_pair_t        all_or;
	aae_pkg::cnt_pair_t        pair_s2;

	for (genvar i = 0; i < aae_pkg::TABLE_SIZE; i++) begin : g_cell
		logic [aae_pkg::CNT_W-1:0] nxt;
		if (i == aae_pkg::TABLE_SIZE - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cnt[i+1];
		end
		aae_cell #(.INDEX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.next_cnt (nxt),
			.cnt      (cnt[i]),
			.pair     (cpair[i])
		);
	end

	always_comb begin
		for (int g = 0; g < aae_pkg::NGROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < aae_pkg::GROUP; k++) begin
				if (g * aae_pkg::GROUP + k < aae_pkg::TABLE_SIZE) begin
					grp_or[g] = grp_or[g] | cpair[g * aae_pkg::GROUP + k];
				end
			end
		end
	end

	always_comb begin
		all_or = '0;
		for (int g = 0; g < aae_pkg::NGROUPS; g++) begin
			all_or = all_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1  <= grp_or;
		pair_s2 <= all_or;
	end

	assign pair  = pair_s2;
	assign total = cnt[aae_pkg::TOTAL_INDEX];

endmodule
`default_nettype wire

@@ src/aae_div.sv @@
`default_nettype none
module aae_div #(
	parameter int NW = 34,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;

	assign sh   = {rem_q, num_q[NW-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule
`default_nettype wire

@@ src/adaptive_arithmetic_encoder_top.sv @@
// Adaptive order-0 arithmetic encoder. One request carries a symbol (0..255, or 256 for end
// of stream; larger codes are dropped with no result). Each result is a lead bit plus the
// count of inverted bits that follow it; last marks the final result of a request and
// stream_end the flush after end of stream, after which the coder is back at its reset state.
// The 258 cumulative counts live in a row of cells, each passing its count to its lower
// neighbor for the symbol lookup. A request runs through the table lookup, the multiply,
// the start and the bit-serial divisions, at most CODE_BITS renormalization steps and, at
// end of stream, the flush; a new symbol is taken only when the coder is idle again.
// Results stall the coder only while one result is held and the output register is full
// and not taken.
`default_nettype none
module adaptive_arithmetic_encoder_top #(
	parameter int CODE_BITS = 17,
	parameter int FREQ_BITS = 15
) (
	input wire logic  clk,
	input wire logic  arst_n,
	aae_sym_if.sink   sym_ch,
	aae_res_if.source res_ch
);

	localparam int CB = CODE_BITS;
	localparam int PW = CODE_BITS + 1 + aae_pkg::CNT_W;
	localparam int SW = $clog2(CODE_BITS);
	localparam logic [CB-1:0] MASK    = {CB{1'b1}};
	localparam logic [CB-1:0] QUARTER = {2'b01, {(CB-2){1'b0}}};
	localparam logic [CB-1:0] HALF    = {2'b10, {(CB-2){1'b0}}};
	localparam logic [CB-1:0] THREEQ  = {2'b11, {(CB-2){1'b0}}};
	localparam logic [aae_pkg::CNT_W-1:0] FREQ_LIMIT =
		aae_pkg::CNT_W'((32'd1 << FREQ_BITS) - 32'd1);

	function automatic logic [aae_pkg::PEND_W-1:0] sat_inc(
		input logic [aae_pkg::PEND_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	aae_pkg::state_t   state_q, state_d;
	aae_pkg::phase_t   phase_q;
	aae_pkg::tbl_ctl_t tctl;
	aae_pkg::cnt_pair_t tpair;
	logic [aae_pkg::CNT_W-1:0] total;

	logic [aae_pkg::SYM_W-1:0]  sym_q;
	logic [CB-1:0]              low_q, high_q;
	logic [aae_pkg::PEND_W-1:0] pending_q;
	logic                       frozen_q;
	logic [SW-1:0]              step_q;
	logic [PW-1:0]              prod_lo_q, prod_hi_q;
	logic [aae_pkg::CNT_W-1:0]  tot_q;

	logic                       held_valid_q, held_bit_q, held_end_q;
	logic [aae_pkg::PEND_W-1:0] held_follow_q;
	logic                       out_valid_q, out_bit_q, out_last_q, out_end_q;
	logic [aae_pkg::PEND_W-1:0] out_follow_q;

	logic [CB:0]   range;
	logic          div_start, dlo_done, dhi_done, div_done;
	logic [PW-1:0] qlo, qhi;
	logic          can_push, stall, step_emit, step_e3, step_bit, step_end;
	logic          gen_res, push_held, push_last, new_bit, new_end, accept;
	logic [CB-1:0] nl_adj, nh_adj;
	logic [aae_pkg::PEND_W-1:0] new_follow;

	assign accept = sym_ch.valid && sym_ch.ready;
	assign range  = {1'b0, high_q - low_q} + 1'b1;

	aae_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.pair   (tpair),
		.total  (total)
	);

	aae_div #(.NW(PW), .DW(aae_pkg::CNT_W)) u_div_lo (
		.clk (clk), .arst_n (arst_n), .start (div_start),
		.num (prod_lo_q), .den (tot_q), .done (dlo_done), .quot (qlo)
	);

	aae_div #(.NW(PW), .DW(aae_pkg::CNT_W)) u_div_hi (
		.clk (clk), .arst_n (arst_n), .start (div_start),
		.num (prod_hi_q), .den (tot_q), .done (dhi_done), .quot (qhi)
	);

	assign div_done = dlo_done && dhi_done;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aae_pkg::ST_IDLE: begin
				if (accept && sym_ch.symbol <= aae_pkg::EOS_SYMBOL) state_d = aae_pkg::ST_LOOK1;
			end
			aae_pkg::ST_LOOK1: state_d = aae_pkg::ST_LOOK2;
			aae_pkg::ST_LOOK2: state_d = aae_pkg::ST_MUL;
			aae_pkg::ST_MUL:   state_d = aae_pkg::ST_START;
			aae_pkg::ST_START: state_d = aae_pkg::ST_DIV;
			aae_pkg::ST_DIV: begin
				if (div_done) state_d = aae_pkg::ST_RENORM;
			end
			aae_pkg::ST_RENORM: begin
				if (step_end) state_d = aae_pkg::ST_FLUSH_DRAIN;
			end
			aae_pkg::ST_FLUSH_DRAIN: begin
				if (phase_q == aae_pkg::PH_DRAIN && (!held_valid_q || can_push))
					state_d = aae_pkg::ST_IDLE;
			end
			default: state_d = aae_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		can_push  = !out_valid_q || res_ch.ready;
		stall     = held_valid_q && !can_push;
		step_emit = (high_q < HALF) || (low_q >= HALF);
		step_bit  = !(high_q < HALF);
		step_e3   = !step_emit && (low_q >= QUARTER) && (high_q < THREEQ);
		step_end  = 1'b0;
		gen_res   = 1'b0;
		new_bit   = step_bit;
		new_end   = 1'b0;
		new_follow = pending_q;
		push_last = 1'b0;
		div_start = 1'b0;
		tctl.sym  = sym_q;
		tctl.inc  = 1'b0;
		tctl.clr  = 1'b0;
		case (state_q)
			aae_pkg::ST_MUL:   tctl.inc = !frozen_q;
			aae_pkg::ST_START: div_start = 1'b1;
			aae_pkg::ST_RENORM: begin
				if (!(step_emit && stall)) begin
					gen_res  = step_emit;
					step_end = (!step_emit && !step_e3) || (step_q == SW'(CB - 1));
				end
			end
			aae_pkg::ST_FLUSH_DRAIN: begin
				if (phase_q == aae_pkg::PH_FLUSH) begin
					if (!stall) begin
						gen_res    = 1'b1;
						new_bit    = !(low_q < QUARTER);
						new_end    = 1'b1;
						new_follow = sat_inc(pending_q);
						tctl.clr   = 1'b1;
					end
				end else begin
					push_last = 1'b1;
				end
			end
			default: ;
		endcase
		push_held = held_valid_q && ((gen_res) || (push_last && can_push));
		nl_adj = step_e3 ? low_q - QUARTER : low_q;
		nh_adj = step_e3 ? high_q - QUARTER : high_q;
	end

	assign sym_ch.ready = (state_q == aae_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= aae_pkg::ST_IDLE;
			phase_q      <= aae_pkg::PH_FLUSH;
			low_q        <= '0;
			high_q       <= MASK;
			pending_q    <= '0;
			frozen_q     <= 1'b0;
			step_q       <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == aae_pkg::ST_START && total >= FREQ_LIMIT) frozen_q <= 1'b1;
			if (state_q == aae_pkg::ST_DIV && div_done) begin
				high_q <= low_q + qhi[CB-1:0] - 1'b1;
				low_q  <= low_q + qlo[CB-1:0];
				step_q <= '0;
			end
			if (state_q == aae_pkg::ST_RENORM && !(step_emit && stall)
				&& (step_emit || step_e3)) begin
				high_q <= {nh_adj[CB-2:0], 1'b1};
				low_q  <= {nl_adj[CB-2:0], 1'b0};
				step_q <= step_q + 1'b1;
				pending_q <= step_emit ? '0 : sat_inc(pending_q);
			end
			if (step_end) begin
				phase_q <= (sym_q == aae_pkg::EOS_SYMBOL) ? aae_pkg::PH_FLUSH : aae_pkg::PH_DRAIN;
			end
			if (state_q == aae_pkg::ST_FLUSH_DRAIN && phase_q == aae_pkg::PH_FLUSH && !stall) begin
				phase_q   <= aae_pkg::PH_DRAIN;
				low_q     <= '0;
				high_q    <= MASK;
				pending_q <= '0;
				frozen_q  <= 1'b0;
			end
			if (gen_res) begin
				held_valid_q <= 1'b1;
			end else if (push_held) begin
				held_valid_q <= 1'b0;
			end
			if (push_held) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) sym_q <= sym_ch.symbol;
		if (state_q == aae_pkg::ST_MUL) begin
			prod_lo_q <= PW'(range) * PW'(tpair.lo_cnt);
			prod_hi_q <= PW'(range) * PW'(tpair.hi_cnt);
			tot_q     <= (total == '0) ? aae_pkg::CNT_W'(1) : total;
		end
		if (gen_res) begin
			held_bit_q    <= new_bit;
			held_end_q    <= new_end;
			held_follow_q <= new_follow;
		end
		if (push_held) begin
			out_bit_q    <= held_bit_q;
			out_end_q    <= held_end_q;
			out_follow_q <= held_follow_q;
			out_last_q   <= push_last;
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.lead_bit     = out_bit_q;
	assign res_ch.follow_count = out_follow_q;
	assign res_ch.last         = out_last_q;
	assign res_ch.stream_end   = out_end_q;

endmodule
`default_nettype wire

@@ src/aae_chk.sv @@
`default_nettype none
module aae_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      sym_valid,
	input wire logic                      sym_ready,
	input wire logic [aae_pkg::SYM_W-1:0] sym_symbol,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic                      res_last,
	input wire logic                      res_stream_end
);

	// flush result always closes its request
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stream_end |-> res_last)
		else $error("stream_end without last");

	// a coded symbol blocks the next request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_ready && (sym_symbol <= aae_pkg::EOS_SYMBOL) |=> !sym_ready)
		else $error("ready right after coded symbol");

	// a dropped symbol leaves the coder idle
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_ready && (sym_symbol > aae_pkg::EOS_SYMBOL) |=> sym_ready)
		else $error("dropped symbol started work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn");

endmodule

bind adaptive_arithmetic_encoder_top aae_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.sym_valid      (sym_ch.valid),
	.sym_ready      (sym_ch.ready),
	.sym_symbol     (sym_ch.symbol),
	.res_valid      (res_ch.valid),
	.res_ready      (res_ch.ready),
	.res_last       (res_ch.last),
	.res_stream_end (res_ch.stream_end)
);
`default_nettype wire

@@ sim/tb_adaptive_arithmetic_encoder_top.sv @@
`default_nettype none
module tb_adaptive_arithmetic_encoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CODE_BITS = 17;
	localparam int FREQ_BITS = 15;
	localparam logic [CODE_BITS-1:0] QTR  = CODE_BITS'(1 << (CODE_BITS - 2));
	localparam logic [CODE_BITS-1:0] HLF  = CODE_BITS'(1 << (CODE_BITS - 1));
	localparam logic [CODE_BITS-1:0] TQTR = CODE_BITS'(3 << (CODE_BITS - 2));
	localparam int FREQ_LIMIT = (1 << FREQ_BITS) - 1;
	localparam logic [aae_pkg::SYM_W-1:0] SYM_BAD_MIN = 9'd257;
	localparam logic [aae_pkg::SYM_W-1:0] SYM_BAD_MAX = 9'd511;

	typedef struct packed {
		logic        lead_bit;
		logic [31:0] follow_count;
		logic        last;
		logic        stream_end;
	} code_bits_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   failed = 1'b0;

	aae_sym_if sym_ch ();
	aae_res_if res_ch ();

	adaptive_arithmetic_encoder_top #(.CODE_BITS(CODE_BITS), .FREQ_BITS(FREQ_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .sym_ch(sym_ch.sink), .res_ch(res_ch.source));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [15:0]          cum_tbl [aae_pkg::TABLE_SIZE];
	bit                   frozen;
	logic [CODE_BITS-1:0] iv_low, iv_high;
	logic [31:0]          pend;
	code_bits_t           expected_bits [$];

	function automatic void coder_reset();
		for (int i = 0; i < aae_pkg::TABLE_SIZE; i++) cum_tbl[i] = 16'(i);
		frozen = 1'b0;
		iv_low = '0;
		iv_high = '1;
		pend = 32'd0;
	endfunction

	function automatic void add_bit(logic b, logic fin);
		code_bits_t item;
		item = '{b, pend, 1'b0, fin};
		expected_bits = {expected_bits, item};
		pend = 32'd0;
	endfunction

	function automatic void bump_pending();
		if (pend != 32'hFFFF_FFFF) pend++;
	endfunction

	function automatic void encode_symbol(logic [aae_pkg::SYM_W-1:0] s);
		longint unsigned lo_c, hi_c, tot, rng;
		logic [CODE_BITS-1:0] nl, nh;
		int n0;
		n0 = expected_bits.size();
		if (s > aae_pkg::EOS_SYMBOL) return;
		lo_c = cum_tbl[s];
		hi_c = cum_tbl[s + 1];
		tot = cum_tbl[aae_pkg::TOTAL_INDEX];
		if (tot == 0) tot = 1;
		if (!frozen) begin
			for (int i = s + 1; i < aae_pkg::TABLE_SIZE; i++) cum_tbl[i] = cum_tbl[i] + 16'd1;
			if (cum_tbl[aae_pkg::TOTAL_INDEX] >= FREQ_LIMIT) frozen = 1'b1;
		end
		rng = longint'(CODE_BITS'(iv_high - iv_low)) + 1;
		nh = CODE_BITS'(iv_low + rng * hi_c / tot - 1);
		nl = CODE_BITS'(iv_low + rng * lo_c / tot);
		for (int i = 0; i < CODE_BITS; i++) begin
			if (nh < HLF) add_bit(1'b0, 1'b0);
			else if (nl >= HLF) add_bit(1'b1, 1'b0);
			else if (nl >= QTR && nh < TQTR) begin
				bump_pending();
				nl -= QTR;
				nh -= QTR;
			end else break;
			nh = (nh << 1) | 1'b1;
			nl = nl << 1;
		end
		iv_low = nl;
		iv_high = nh;
		if (s == aae_pkg::EOS_SYMBOL) begin
			bump_pending();
			add_bit(iv_low < QTR ? 1'b0 : 1'b1, 1'b1);
			coder_reset();
		end
		if (expected_bits.size() > n0) expected_bits[$].last = 1'b1;
	endfunction

	// directed table; expected lead/count given only for the first row after reset
	typedef struct {
		logic [aae_pkg::SYM_W-1:0] s;
		bit                        typed;
		code_bits_t                first;
	} dir_row_t;

	dir_row_t dir_tbl [] = '{
		'{9'd0,   1'b1, '{1'b0, 32'd0, 1'b0, 1'b0}},
		'{9'd255, 1'b0, '0}, '{aae_pkg::EOS_SYMBOL, 1'b0, '0},
		'{aae_pkg::EOS_SYMBOL, 1'b0, '0}, '{SYM_BAD_MIN, 1'b0, '0}, '{SYM_BAD_MAX, 1'b0, '0},
		'{9'd128, 1'b0, '0}, '{9'd127, 1'b0, '0}, '{9'd64, 1'b0, '0},
		'{9'd1, 1'b0, '0}, '{9'd2, 1'b0, '0}, '{9'd4, 1'b0, '0}, '{9'd8, 1'b0, '0},
		'{9'd16, 1'b0, '0}, '{9'd32, 1'b0, '0}, '{9'd170, 1'b0, '0},
		'{9'd85, 1'b0, '0}, '{9'd255, 1'b0, '0}, '{9'd255, 1'b0, '0},
		'{9'd0, 1'b0, '0}, '{aae_pkg::EOS_SYMBOL, 1'b0, '0}
	};

	int typed_idx = -1;
	code_bits_t typed_val;

	task automatic send_symbol(logic [aae_pkg::SYM_W-1:0] s);
		sym_ch.valid <= 1'b1;
		sym_ch.symbol <= s;
		do @(posedge clk); while (!sym_ch.ready);
		encode_symbol(s);
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
		if (g > 0) begin
			sym_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [aae_pkg::SYM_W-1:0] rand_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return aae_pkg::EOS_SYMBOL;
		if (r < 9) return 9'($urandom_range(257, 511));
		if (r < 50) return 9'($urandom_range(0, 255));
		return 9'($urandom_range(97, 102));
	endfunction

	int checked = 0;
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			code_bits_t got, exp_v;
			got = '{res_ch.lead_bit, res_ch.follow_count, res_ch.last, res_ch.stream_end};
			if (expected_bits.size() == 0) begin
				$display("%0t unexpected request: got %p", $time, got);
				failed = 1'b1;
			end else begin
				exp_v = expected_bits.pop_front();
				if (checked == typed_idx && typed_val !== exp_v) begin
					$display("%0t typed row disagrees: exp %p act %p", $time, typed_val, exp_v);
					failed = 1'b1;
				end
				if (got.lead_bit !== exp_v.lead_bit)
					$display("%0t lead_bit: exp %0d act %0d", $time, exp_v.lead_bit, got.lead_bit);
				if (got.follow_count !== exp_v.follow_count)
					$display("%0t follow_count: exp %0d act %0d", $time,
						exp_v.follow_count, got.follow_count);
				if (got.last !== exp_v.last)
					$display("%0t last: exp %0d act %0d", $time, exp_v.last, got.last);
				if (got.stream_end !== exp_v.stream_end)
					$display("%0t stream_end: exp %0d act %0d", $time,
						exp_v.stream_end, got.stream_end);
				if (got !== exp_v) failed = 1'b1;
			end
			checked++;
		end
	end

	// receiver stall pattern: open, lightly stalled and choked stretches in turn
	int stall_ctr = 0;
	always @(posedge clk) begin
		stall_ctr <= stall_ctr + 1;
		case ((stall_ctr / 64) % 3)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 3) != 0);
			default: res_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	initial begin
		res_ch.ready = 1'b0;
		sym_ch.valid = 1'b0;
		sym_ch.symbol = '0;
		coder_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].typed && typed_idx < 0) begin
				typed_idx = checked + expected_bits.size();
				typed_val = dir_tbl[i].first;
			end
			send_symbol(dir_tbl[i].s);
			if ($urandom_range(0, 1)) idle_gap();
		end
		for (int n = 0; n < 105; ) begin
			int burst;
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				logic [aae_pkg::SYM_W-1:0] s;
				s = rand_symbol();
				send_symbol(s);
				if (s <= aae_pkg::EOS_SYMBOL) n++;
			end
			idle_gap();
		end
		send_symbol(aae_pkg::EOS_SYMBOL);
		sym_ch.valid <= 1'b0;
		while (expected_bits.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
